>>> hdl/bmprle8_pkg.sv
package bmprle8_pkg;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 1;

  localparam int DATA_BYTE_W = 8;
  localparam int PIXEL_X_W   = 12;
  localparam int PIXEL_Y_W   = 12;
  localparam int RUN_LEN_W   = 8;
  localparam int COLOR_W     = 8;

  localparam logic [DATA_BYTE_W-1:0] ESC_END_OF_LINE    = 8'd0;
  localparam logic [DATA_BYTE_W-1:0] ESC_END_OF_PICTURE = 8'd1;
  localparam logic [DATA_BYTE_W-1:0] ESC_DELTA          = 8'd2;
  localparam logic [DATA_BYTE_W-1:0] COUNT_ESCAPE       = 8'd0;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_COUNT   = 3'd0,
    PH_INDEX   = 3'd1,
    PH_ESCAPE  = 3'd2,
    PH_DX      = 3'd3,
    PH_DY      = 3'd4,
    PH_LITERAL = 3'd5,
    PH_PAD     = 3'd6
  } phase_t;

  typedef struct packed {
    logic [DATA_BYTE_W-1:0] data_byte;
    logic                   frame_start;
  } in_item_t;

  typedef struct packed {
    logic [PIXEL_X_W-1:0] pixel_x;
    logic [PIXEL_Y_W-1:0] pixel_y;
    logic [RUN_LEN_W-1:0] run_length;
    logic [COLOR_W-1:0]   color_index;
    logic                 picture_done;
  } out_item_t;

endpackage

>>> hdl/bmp_rle8_run_decoder_unit.sv
// RLE8 bitmap stream decoder. Takes one compressed byte per cycle while
// in_stall is low: each accepted byte is decoded in the cycle it is taken,
// using the phase, column and row registers, and its run (if any) is
// registered into the output register, or into the one-entry skid stage
// behind it when the output is stalled, so input keeps flowing while a
// result waits; in_stall rises only when both the output register and the
// skid stage hold results. At most one result per byte; end of picture or
// row underflow gives a zero-length result with picture_done set, after
// which bytes are dropped until frame_start. Width and height writes belong
// to idle periods; height takes effect at the next frame_start.
module bmp_rle8_run_decoder_unit #(
  parameter int MAX_WIDTH  = bmprle8_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bmprle8_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  bmprle8_pkg::in_item_t               in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output bmprle8_pkg::out_item_t              out_data,
  input  logic                                cfg_write_en,
  input  logic [bmprle8_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bmprle8_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int COL_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int LW    = (COL_W > 8) ? COL_W : 8;
  localparam int SW    = LW + 1;
  localparam int RW    = (ROW_W > 8) ? ROW_W : 8;
  localparam int CW    = bmprle8_pkg::CFG_DATA_W;

  logic [CW-1:0] frame_width;
  logic [CW-1:0] frame_height;

  bmprle8_pkg::phase_t phase, phase_next, cur_phase;
  logic [COL_W-1:0] column, column_next, cur_column;
  logic [ROW_W-1:0] row, row_next, cur_row, start_row;
  logic [7:0]       pending_count, pending_count_next, cur_pending;
  logic [7:0]       literal_left, literal_left_next, cur_literal;
  logic             pad_pending, pad_pending_next, cur_pad;
  logic             finished, finished_next, cur_finished;

  logic [COL_W-1:0] eff_width;
  logic [7:0]       add_n;
  logic [SW-1:0]    col_sum;
  logic [COL_W-1:0] col_adv;
  logic [LW-1:0]    room;
  logic [LW-1:0]    run_len;
  logic [7:0]       lit_dec;
  logic [7:0]       b;

  logic                   accept;
  logic                   res_valid;
  bmprle8_pkg::out_item_t res;

  logic                   skid_valid;
  bmprle8_pkg::out_item_t skid_data;

  assign b      = in_data.data_byte;
  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CW'(1);
      frame_height <= CW'(1);
    end else if (cfg_write_en) begin
      if (cfg_index == bmprle8_pkg::CFG_IMAGE_WIDTH) begin
        frame_width <= cfg_data;
      end else if (cfg_index == bmprle8_pkg::CFG_IMAGE_HEIGHT) begin
        frame_height <= cfg_data;
      end
    end
  end

  always_comb begin
    if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      eff_width = COL_W'(MAX_WIDTH);
    end else begin
      eff_width = COL_W'(frame_width);
    end
    if (frame_height == '0) begin
      start_row = '0;
    end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
      start_row = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      start_row = ROW_W'(frame_height - CW'(1));
    end
  end

  // frame_start restarts position before the byte is decoded
  always_comb begin
    if (in_data.frame_start) begin
      cur_phase    = bmprle8_pkg::PH_COUNT;
      cur_column   = '0;
      cur_row      = start_row;
      cur_pending  = '0;
      cur_literal  = '0;
      cur_pad      = 1'b0;
      cur_finished = 1'b0;
    end else begin
      cur_phase    = phase;
      cur_column   = column;
      cur_row      = row;
      cur_pending  = pending_count;
      cur_literal  = literal_left;
      cur_pad      = pad_pending;
      cur_finished = finished;
    end
  end

  always_comb begin
    case (cur_phase)
      bmprle8_pkg::PH_INDEX:   add_n = cur_pending;
      bmprle8_pkg::PH_LITERAL: add_n = 8'd1;
      default:                 add_n = b;
    endcase
    col_sum = SW'(cur_column) + SW'(add_n);
    if (col_sum > SW'(MAX_WIDTH)) begin
      col_adv = COL_W'(MAX_WIDTH);
    end else begin
      col_adv = COL_W'(col_sum);
    end
    room = LW'(eff_width) - LW'(cur_column);
    if (LW'(cur_pending) > room) begin
      run_len = room;
    end else begin
      run_len = LW'(cur_pending);
    end
    lit_dec = cur_literal - 8'd1;
  end

  // next state
  always_comb begin
    phase_next         = cur_phase;
    column_next        = cur_column;
    row_next           = cur_row;
    pending_count_next = cur_pending;
    literal_left_next  = cur_literal;
    pad_pending_next   = cur_pad;
    finished_next      = cur_finished;
    if (!cur_finished) begin
      case (cur_phase)
        bmprle8_pkg::PH_INDEX: begin
          column_next = col_adv;
          phase_next  = bmprle8_pkg::PH_COUNT;
        end
        bmprle8_pkg::PH_ESCAPE: begin
          if (b == bmprle8_pkg::ESC_END_OF_LINE) begin
            column_next = '0;
            phase_next  = bmprle8_pkg::PH_COUNT;
            if (cur_row == '0) begin
              finished_next = 1'b1;
            end else begin
              row_next = cur_row - ROW_W'(1);
            end
          end else if (b == bmprle8_pkg::ESC_END_OF_PICTURE) begin
            finished_next = 1'b1;
            phase_next    = bmprle8_pkg::PH_COUNT;
          end else if (b == bmprle8_pkg::ESC_DELTA) begin
            phase_next = bmprle8_pkg::PH_DX;
          end else begin
            literal_left_next = b;
            pad_pending_next  = b[0];
            phase_next        = bmprle8_pkg::PH_LITERAL;
          end
        end
        bmprle8_pkg::PH_DX: begin
          column_next = col_adv;
          phase_next  = bmprle8_pkg::PH_DY;
        end
        bmprle8_pkg::PH_DY: begin
          phase_next = bmprle8_pkg::PH_COUNT;
          if (RW'(b) > RW'(cur_row)) begin
            finished_next = 1'b1;
          end else begin
            row_next = cur_row - ROW_W'(b);
          end
        end
        bmprle8_pkg::PH_LITERAL: begin
          column_next       = col_adv;
          literal_left_next = lit_dec;
          if (lit_dec == '0) begin
            phase_next = cur_pad ? bmprle8_pkg::PH_PAD : bmprle8_pkg::PH_COUNT;
          end
        end
        bmprle8_pkg::PH_PAD: begin
          pad_pending_next = 1'b0;
          phase_next       = bmprle8_pkg::PH_COUNT;
        end
        default: begin
          if (b == bmprle8_pkg::COUNT_ESCAPE) begin
            phase_next = bmprle8_pkg::PH_ESCAPE;
          end else begin
            pending_count_next = b;
            phase_next         = bmprle8_pkg::PH_INDEX;
          end
        end
      endcase
    end
  end

  // result of this byte
  always_comb begin
    res_valid        = 1'b0;
    res.pixel_x      = bmprle8_pkg::PIXEL_X_W'(cur_column);
    res.pixel_y      = bmprle8_pkg::PIXEL_Y_W'(cur_row);
    res.run_length   = '0;
    res.color_index  = b;
    res.picture_done = 1'b0;
    if (!cur_finished) begin
      case (cur_phase)
        bmprle8_pkg::PH_INDEX: begin
          res.run_length = 8'(run_len);
          res_valid      = (cur_column < eff_width) && (run_len != '0);
        end
        bmprle8_pkg::PH_LITERAL: begin
          res.run_length = 8'd1;
          res_valid      = cur_column < eff_width;
        end
        default: begin
          res_valid = finished_next;
        end
      endcase
      if (finished_next) begin
        res.pixel_x      = '0;
        res.pixel_y      = '0;
        res.run_length   = '0;
        res.color_index  = '0;
        res.picture_done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= bmprle8_pkg::PH_COUNT;
      column        <= '0;
      row           <= '0;
      pending_count <= '0;
      literal_left  <= '0;
      pad_pending   <= 1'b0;
      finished      <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      column        <= column_next;
      row           <= row_next;
      pending_count <= pending_count_next;
      literal_left  <= literal_left_next;
      pad_pending   <= pad_pending_next;
      finished      <= finished_next;
    end
  end

  // output register plus skid stage
  assign in_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_stall) begin
      if (accept && res_valid) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= accept && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_stall) begin
      if (accept && res_valid) begin
        skid_data <= res;
      end
    end else if (skid_valid) begin
      out_data <= skid_data;
    end else if (accept && res_valid) begin
      out_data <= res;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a result while output register is empty");

  a_done_is_blank: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.picture_done) |->
      (out_data.run_length == '0 && out_data.pixel_x == '0 && out_data.pixel_y == '0))
    else $error("end result carries a run");

  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.picture_done) |-> (out_data.run_length != '0))
    else $error("empty run delivered");

  a_column_bound: assert property (@(posedge clk) disable iff (rst)
    32'(column) <= 32'(MAX_WIDTH))
    else $error("column beyond saturation limit");

endmodule
